[rtl/lsb_first_bit_packer_defines.svh]
// Assertion helpers for the bit packer. Both sample on clk and are
// disabled while rst_n is low; the user module must have both names.
`ifndef LSB_FIRST_BIT_PACKER_DEFINES_SVH
`define LSB_FIRST_BIT_PACKER_DEFINES_SVH

// Whenever cond holds, prop must hold in the same cycle.
`define LBP_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("lbp assertion failed");

// prop must hold at every sampled edge.
`define LBP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lbp assertion failed");

`endif

[rtl/lbp_pkg.sv]
`timescale 1ns / 1ps

package lbp_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 1024;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int BCOUNT_W = 6;
  localparam int ADDR_W   = 10;
  localparam int CNT_W    = 11;
  localparam int BITPOS_W = 14;

  localparam logic [CNT_W-1:0]    MAX_SIZE_RESET = 11'd1024;
  localparam logic [CNT_W-1:0]    FIELD_HEADROOM = 11'd4;
  localparam logic [BCOUNT_W-1:0] MAX_FIELD_BITS = 6'd32;

  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_BIT   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_BITS  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_BYTE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SHORT = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_LONG  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd6;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_BITS   = 5'b00010,
    S_APPEND = 5'b00100,
    S_READ   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

endpackage

[rtl/lbp_byte_ram.sv]
`timescale 1ns / 1ps

// Byte store: one write port, one read port, registered read data.
module lbp_byte_ram #(
  parameter int unsigned DEPTH = lbp_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned AW    = $clog2(lbp_pkg::BUFFER_BYTES_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/lsb_first_bit_packer.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       sink       in_valid / in_stall  action, value, bit_count, byte_address
// out_      source     out_valid/out_stall  read_data, overflow, bytes_used, bit_position
// cfg_      sink       cfg_write_en         max_size (cfg_write_data)
//
// Every transaction runs from S_IDLE to S_DONE: clear, no-op and refused writes go
// there directly, a read passes S_READ, byte/short/long pass S_APPEND once per byte
// (one RAM write per byte), write bit and write bits pass S_BITS once per touched byte.
// This pace is set by the single RAM write port and the shared chunk shifter.
// rst_n is synchronous, active low; the byte store has no reset.
// The input is stalled while a transaction is in work; the output register
// lets the next input transaction in while a result waits on out_stall.
module lsb_first_bit_packer #(
  parameter int unsigned BUFFER_BYTES = lbp_pkg::BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transactions
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lbp_pkg::ACTION_W-1:0]  in_action,
  input  logic [lbp_pkg::VALUE_W-1:0]   in_value,
  input  logic [lbp_pkg::BCOUNT_W-1:0]  in_bit_count,
  input  logic [lbp_pkg::ADDR_W-1:0]    in_byte_address,
  // results
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_read_data,
  output logic                          out_overflow,
  output logic [lbp_pkg::CNT_W-1:0]     out_bytes_used,
  output logic [lbp_pkg::BITPOS_W-1:0]  out_bit_position,
  // configuration
  input  logic                          cfg_write_en,
  input  logic [lbp_pkg::CNT_W-1:0]     cfg_write_data
);

`include "lsb_first_bit_packer_defines.svh"

  localparam int unsigned AW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [16:0] BUF17 = 17'(BUFFER_BYTES);

  // control state
  lbp_pkg::state_t state_r, state_nxt;
  logic [lbp_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;     // byte count
  logic [lbp_pkg::BITPOS_W-1:0] bp_r, bp_nxt;       // bit pointer
  logic                         ovf_r, ovf_nxt;     // sticky overflow
  logic [lbp_pkg::CNT_W-1:0]    max_r;              // max_size register
  logic                         out_valid_r, out_valid_nxt;

  // per-transaction working registers
  logic [lbp_pkg::VALUE_W-1:0]  data_r, data_nxt;   // bits still to place
  logic [lbp_pkg::BCOUNT_W-1:0] rem_r, rem_nxt;     // bits or bytes left
  logic [7:0]                   part_r, part_nxt;   // copy of the partial byte
  logic [lbp_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic                         hit_r, hit_nxt;     // read lands inside the data

  // result register
  logic [7:0]                   out_rd_r, out_rd_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic [lbp_pkg::CNT_W-1:0]    out_cnt_r, out_cnt_nxt;
  logic [lbp_pkg::BITPOS_W-1:0] out_bp_r, out_bp_nxt;

  // headroom
  logic [lbp_pkg::CNT_W-1:0]    lim, room;
  logic                         fits1, fits2, fits4;
  logic [lbp_pkg::BCOUNT_W-1:0] bc_clip;

  // shared chunk unit
  logic [2:0]                   sub;
  logic                         open_byte;
  logic [3:0]                   room_bits, n_bits, shamt;
  logic [7:0]                   mask, chunk, sh_byte, new_byte;
  logic [lbp_pkg::BITPOS_W-1:0] base_bp;
  logic [lbp_pkg::VALUE_W-1:0]  data_shift;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // A usable size beyond the store is clipped to it; a count past the
  // limit leaves no headroom at all.
  assign lim   = ({6'd0, max_r} < BUF17) ? max_r : BUF17[lbp_pkg::CNT_W-1:0];
  assign room  = (cnt_r <= lim) ? (lim - cnt_r) : '0;
  assign fits1 = (room >= 11'd1);
  assign fits2 = (room >= 11'd2);
  assign fits4 = (room >= lbp_pkg::FIELD_HEADROOM);
  assign bc_clip = (in_bit_count > lbp_pkg::MAX_FIELD_BITS) ? lbp_pkg::MAX_FIELD_BITS
                                                            : in_bit_count;

  // One chunk per cycle: as many bits as are left, up to the end of the
  // current byte. A pointer on a byte boundary opens a zeroed byte at the count.
  assign sub       = bp_r[2:0];
  assign open_byte = (sub == 3'd0);
  assign room_bits = 4'd8 - {1'b0, sub};
  assign n_bits    = ({2'b00, room_bits} < rem_r) ? room_bits : rem_r[3:0];
  assign mask      = 8'((9'd1 << n_bits) - 9'd1);
  assign chunk     = data_r[7:0] & mask;
  assign sh_byte   = chunk << sub;
  assign new_byte  = (open_byte ? 8'd0 : part_r) | sh_byte;
  assign base_bp   = open_byte ? {cnt_r, 3'b000} : bp_r;

  // Same shifter drains whole bytes for appends.
  assign shamt      = (state_r == lbp_pkg::S_APPEND) ? 4'd8 : n_bits;
  assign data_shift = data_r >> shamt;

  assign ram_we    = (state_r == lbp_pkg::S_BITS) || (state_r == lbp_pkg::S_APPEND);
  assign ram_waddr = ((state_r == lbp_pkg::S_BITS) && !open_byte) ? AW'(bp_r[13:3])
                                                                   : AW'(cnt_r);
  assign ram_wdata = (state_r == lbp_pkg::S_APPEND) ? data_r[7:0] : new_byte;
  assign ram_raddr = AW'(addr_r);

  lbp_byte_ram #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bp_nxt        = bp_r;
    ovf_nxt       = ovf_r;
    data_nxt      = data_r;
    rem_nxt       = rem_r;
    part_nxt      = part_r;
    addr_nxt      = addr_r;
    hit_nxt       = hit_r;
    out_rd_nxt    = out_rd_r;
    out_ovf_nxt   = out_ovf_r;
    out_cnt_nxt   = out_cnt_r;
    out_bp_nxt    = out_bp_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lbp_pkg::S_IDLE: begin
        if (in_valid) begin
          data_nxt  = in_value;
          addr_nxt  = in_byte_address;
          hit_nxt   = 1'b0;
          state_nxt = lbp_pkg::S_DONE;
          case (in_action)
            lbp_pkg::ACT_CLEAR: begin
              cnt_nxt = '0;
              bp_nxt  = '0;
              ovf_nxt = 1'b0;
            end
            lbp_pkg::ACT_BIT: begin
              if (open_byte && !fits1) begin
                ovf_nxt = 1'b1;
              end else begin
                rem_nxt   = 6'd1;
                state_nxt = lbp_pkg::S_BITS;
              end
            end
            lbp_pkg::ACT_BITS: begin
              // headroom is checked even for an empty field
              if (!fits4) begin
                ovf_nxt = 1'b1;
              end else if (bc_clip != 6'd0) begin
                rem_nxt   = bc_clip;
                state_nxt = lbp_pkg::S_BITS;
              end
            end
            lbp_pkg::ACT_BYTE: begin
              if (fits1) begin
                rem_nxt   = 6'd1;
                state_nxt = lbp_pkg::S_APPEND;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            lbp_pkg::ACT_SHORT: begin
              if (fits2) begin
                rem_nxt   = 6'd2;
                state_nxt = lbp_pkg::S_APPEND;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            lbp_pkg::ACT_LONG: begin
              if (fits4) begin
                rem_nxt   = 6'd4;
                state_nxt = lbp_pkg::S_APPEND;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            lbp_pkg::ACT_READ: begin
              hit_nxt   = ({1'b0, in_byte_address} < cnt_r) &&
                          ({7'd0, in_byte_address} < BUF17);
              state_nxt = lbp_pkg::S_READ;
            end
            default: begin
              // no-op: report state only
            end
          endcase
        end
      end

      lbp_pkg::S_BITS: begin
        cnt_nxt  = open_byte ? (cnt_r + 11'd1) : cnt_r;
        bp_nxt   = base_bp + 14'(n_bits);
        part_nxt = new_byte;
        data_nxt = data_shift;
        rem_nxt  = rem_r - 6'(n_bits);
        if (rem_r == 6'(n_bits)) begin
          state_nxt = lbp_pkg::S_DONE;
        end
      end

      lbp_pkg::S_APPEND: begin
        cnt_nxt  = cnt_r + 11'd1;
        data_nxt = data_shift;
        rem_nxt  = rem_r - 6'd1;
        if (rem_r == 6'd1) begin
          state_nxt = lbp_pkg::S_DONE;
        end
      end

      lbp_pkg::S_READ: begin
        // RAM latches the byte this cycle
        state_nxt = lbp_pkg::S_DONE;
      end

      lbp_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = hit_r ? ram_rdata : 8'd0;
          out_ovf_nxt   = ovf_r;
          out_cnt_nxt   = cnt_r;
          out_bp_nxt    = bp_r;
          state_nxt     = lbp_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lbp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbp_pkg::S_IDLE;
      cnt_r       <= '0;
      bp_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bp_r        <= bp_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= lbp_pkg::MAX_SIZE_RESET;
    end else if (cfg_write_en) begin
      max_r <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    rem_r     <= rem_nxt;
    part_r    <= part_nxt;
    addr_r    <= addr_nxt;
    hit_r     <= hit_nxt;
    out_rd_r  <= out_rd_nxt;
    out_ovf_r <= out_ovf_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_bp_r  <= out_bp_nxt;
  end

  assign in_stall         = (state_r != lbp_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_rd_r;
  assign out_overflow     = out_ovf_r;
  assign out_bytes_used   = out_cnt_r;
  assign out_bit_position = out_bp_r;

  // byte count never runs past the store
  `LBP_ASSERT_ALWAYS(a_cnt_in_store, {6'd0, cnt_r} <= BUF17)
  // a pointer inside a byte always refers to a byte already opened
  `LBP_ASSERT_IMP(a_partial_opened, bp_r[2:0] != 3'd0, {1'b0, bp_r[13:3]} < {1'b0, cnt_r})
  // the chunk loop never runs with nothing left
  `LBP_ASSERT_IMP(a_bits_left, state_r == lbp_pkg::S_BITS, (rem_r != 6'd0) && (rem_r <= 6'd32))
  // appends move one to four bytes
  `LBP_ASSERT_IMP(a_append_left, state_r == lbp_pkg::S_APPEND, (rem_r != 6'd0) && (rem_r <= 6'd4))

endmodule

[sim/lsb_first_bit_packer_checker.sv]
`timescale 1ns / 1ps

module lsb_first_bit_packer_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [lbp_pkg::ACTION_W-1:0] in_action,
  input  logic [lbp_pkg::VALUE_W-1:0]  in_value,
  input  logic [lbp_pkg::BCOUNT_W-1:0] in_bit_count,
  input  logic [lbp_pkg::ADDR_W-1:0]   in_byte_address,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [7:0]                   out_read_data,
  input  logic                         out_overflow,
  input  logic [lbp_pkg::CNT_W-1:0]    out_bytes_used,
  input  logic [lbp_pkg::BITPOS_W-1:0] out_bit_position,
  input  logic                         cfg_write_en,
  input  logic [lbp_pkg::CNT_W-1:0]    cfg_write_data,
  output int                           fail_count,
  output int                           pending,
  output logic [lbp_pkg::CNT_W-1:0]    bytes_held
);

  localparam int unsigned STORE_BYTES = lbp_pkg::BUFFER_BYTES_DEF;

  typedef struct packed {
    logic [7:0]                   read_data;
    logic                         overflow;
    logic [lbp_pkg::CNT_W-1:0]    bytes_used;
    logic [lbp_pkg::BITPOS_W-1:0] bit_position;
  } packer_status_t;

  // shadow copy of the packer state
  logic [7:0]     shadow_bytes [STORE_BYTES];
  int unsigned    fill_count;
  int unsigned    bit_ptr;
  int unsigned    size_limit;
  logic           overflow_seen;
  packer_status_t predicted_status [$];
  int             mismatches   = 0;
  int             results_seen = 0;

  assign fail_count = mismatches;

  function automatic bit room_for(int unsigned need);
    int unsigned usable;
    usable = (size_limit < STORE_BYTES) ? size_limit : STORE_BYTES;
    return (fill_count <= usable) && (usable - fill_count >= need);
  endfunction

  // one bit, LSB first; a byte-aligned pointer opens a fresh byte at the fill level
  function automatic void put_bit(logic b);
    int unsigned sub;
    sub = bit_ptr & 7;
    if (sub == 0) begin
      bit_ptr = fill_count * 8;
      if (fill_count < STORE_BYTES) shadow_bytes[fill_count] = 8'h00;
      fill_count++;
    end
    if (b && (bit_ptr >> 3) < STORE_BYTES) shadow_bytes[bit_ptr >> 3][sub] = 1'b1;
    bit_ptr = (bit_ptr + 1) & 'h3FFF;
  endfunction

  function automatic void append_le(logic [lbp_pkg::VALUE_W-1:0] v, int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (fill_count < STORE_BYTES) shadow_bytes[fill_count] = v[8*i +: 8];
      fill_count++;
    end
  endfunction

  function automatic packer_status_t pack_step(logic [lbp_pkg::ACTION_W-1:0] act,
                                               logic [lbp_pkg::VALUE_W-1:0] val,
                                               logic [lbp_pkg::BCOUNT_W-1:0] cnt,
                                               logic [lbp_pkg::ADDR_W-1:0] addr);
    packer_status_t st;
    int unsigned    nbits;
    int unsigned    i;
    st = '0;
    case (act)
      lbp_pkg::ACT_CLEAR: begin
        fill_count    = 0;
        bit_ptr       = 0;
        overflow_seen = 1'b0;
      end
      lbp_pkg::ACT_BIT: begin
        if ((bit_ptr & 7) == 0 && !room_for(1)) overflow_seen = 1'b1;
        else put_bit(val[0]);
      end
      lbp_pkg::ACT_BITS: begin
        nbits = (cnt > lbp_pkg::MAX_FIELD_BITS) ? 32'(lbp_pkg::MAX_FIELD_BITS) : 32'(cnt);
        if (!room_for(32'(lbp_pkg::FIELD_HEADROOM))) overflow_seen = 1'b1;
        else for (i = 0; i < nbits; i++) put_bit(val[i]);
      end
      lbp_pkg::ACT_BYTE: begin
        if (room_for(1)) append_le(val, 1); else overflow_seen = 1'b1;
      end
      lbp_pkg::ACT_SHORT: begin
        if (room_for(2)) append_le(val, 2); else overflow_seen = 1'b1;
      end
      lbp_pkg::ACT_LONG: begin
        if (room_for(4)) append_le(val, 4); else overflow_seen = 1'b1;
      end
      lbp_pkg::ACT_READ: begin
        if (addr < fill_count) st.read_data = shadow_bytes[addr];
      end
      default: ;
    endcase
    st.overflow     = overflow_seen;
    st.bytes_used   = fill_count[lbp_pkg::CNT_W-1:0];
    st.bit_position = bit_ptr[lbp_pkg::BITPOS_W-1:0];
    return st;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    packer_status_t want;
    if (!rst_n) begin
      fill_count    = 0;
      bit_ptr       = 0;
      overflow_seen = 1'b0;
      size_limit    = 32'(lbp_pkg::MAX_SIZE_RESET);
      predicted_status.delete();
    end else begin
      if (cfg_write_en) size_limit = 32'(cfg_write_data);
      // drain before fill so a stray result never matches this edge's transaction
      if (out_valid && !out_stall) begin
        if (predicted_status.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    results_seen));
        end else begin
          want = predicted_status.pop_front();
          if (out_read_data !== want.read_data)
            report_mismatch($sformatf("result %0d read_data: expected %0h, got %0h",
                                      results_seen, want.read_data, out_read_data));
          if (out_overflow !== want.overflow)
            report_mismatch($sformatf("result %0d overflow: expected %0b, got %0b",
                                      results_seen, want.overflow, out_overflow));
          if (out_bytes_used !== want.bytes_used)
            report_mismatch($sformatf("result %0d bytes_used: expected %0d, got %0d",
                                      results_seen, want.bytes_used, out_bytes_used));
          if (out_bit_position !== want.bit_position)
            report_mismatch($sformatf("result %0d bit_position: expected %0d, got %0d",
                                      results_seen, want.bit_position, out_bit_position));
        end
        results_seen++;
      end
      if (in_valid && !in_stall)
        predicted_status.push_back(pack_step(in_action, in_value, in_bit_count,
                                             in_byte_address));
    end
    pending    <= predicted_status.size();
    bytes_held <= fill_count[lbp_pkg::CNT_W-1:0];
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  // action 7 has no name in the package: the packer treats it as a no-op
  localparam logic [lbp_pkg::ACTION_W-1:0] ACT_NOP = 3'd7;

  // slowest legal run: ~1900 transactions, each with its idle input time, stalled
  // output time and work, still well below this limit
  localparam int CYCLE_LIMIT = 1_000_000;

  // random mixes: normal traffic, buffer filling, and mostly read-back
  localparam int STYLE_MIX   = 0;
  localparam int STYLE_FILL  = 1;
  localparam int STYLE_DRAIN = 2;
  localparam int NUM_PHASES  = 12;

  logic                         clk             = 1'b0;
  logic                         rst_n           = 1'b0;
  logic                         in_valid        = 1'b0;
  logic                         in_stall;
  logic [lbp_pkg::ACTION_W-1:0] in_action       = lbp_pkg::ACT_CLEAR;
  logic [lbp_pkg::VALUE_W-1:0]  in_value        = '0;
  logic [lbp_pkg::BCOUNT_W-1:0] in_bit_count    = '0;
  logic [lbp_pkg::ADDR_W-1:0]   in_byte_address = '0;
  logic                         out_valid;
  logic                         out_stall       = 1'b0;
  logic [7:0]                   out_read_data;
  logic                         out_overflow;
  logic [lbp_pkg::CNT_W-1:0]    out_bytes_used;
  logic [lbp_pkg::BITPOS_W-1:0] out_bit_position;
  logic                         cfg_write_en    = 1'b0;
  logic [lbp_pkg::CNT_W-1:0]    cfg_write_data  = '0;

  int                        packer_fail;
  int                        packer_pending;
  logic [lbp_pkg::CNT_W-1:0] packer_bytes_held;

  int cycle_count = 0;
  bit in_burst    = 1'b0;   // stretch of back-to-back input transactions
  int stall_left  = 0;
  bit stall_calm  = 1'b0;   // stretch with out_stall held low

  // per phase: size limit, length, traffic mix, clear first
  // phase 8 shrinks the limit under a nearly full buffer without clearing it
  int phase_limit [NUM_PHASES] = '{1023, 0, 1, 2047, 4, 5, 3, 1024, 6, 1024, 2, 0};
  int phase_items [NUM_PHASES] = '{150, 60, 120, 150, 150, 150, 120, 450, 120, 120, 120, 150};
  int phase_style [NUM_PHASES] = '{STYLE_MIX, STYLE_MIX, STYLE_MIX, STYLE_MIX, STYLE_MIX,
                                   STYLE_MIX, STYLE_MIX, STYLE_FILL, STYLE_DRAIN,
                                   STYLE_MIX, STYLE_MIX, STYLE_MIX};
  bit phase_clear [NUM_PHASES] = '{0, 0, 1, 0, 1, 1, 1, 1, 0, 0, 1, 0};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lsb_first_bit_packer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_value         (in_value),
    .in_bit_count     (in_bit_count),
    .in_byte_address  (in_byte_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_overflow     (out_overflow),
    .out_bytes_used   (out_bytes_used),
    .out_bit_position (out_bit_position),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data)
  );

  lsb_first_bit_packer_checker packer_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_value         (in_value),
    .in_bit_count     (in_bit_count),
    .in_byte_address  (in_byte_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_overflow     (out_overflow),
    .out_bytes_used   (out_bytes_used),
    .out_bit_position (out_bit_position),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .fail_count       (packer_fail),
    .pending          (packer_pending),
    .bytes_held       (packer_bytes_held)
  );

  // Input idle time before a transaction: mostly none or short, now and then long.
  // Bursts flip on and off so some runs go with no idling at all.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    if (in_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Present one transaction and hold it until accepted. Called at a clock edge;
  // returns at the acceptance edge with in_valid still high, so a back-to-back
  // transaction only updates the payload (one NBA per signal per step).
  task automatic send_item(logic [lbp_pkg::ACTION_W-1:0] act,
                           logic [lbp_pkg::VALUE_W-1:0] val,
                           logic [lbp_pkg::BCOUNT_W-1:0] cnt,
                           logic [lbp_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_value        <= val;
    in_bit_count    <= cnt;
    in_byte_address <= addr;
    do @(posedge clk); while (in_stall);
  endtask

  // Wait until every result has come back. packer_pending is registered in the
  // checker, so it lags the queue: step first so a transaction
  // accepted at the current edge is already counted.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (packer_pending != 0) @(posedge clk);
  endtask

  // max_size only changes with the packer idle
  task automatic set_limit(logic [lbp_pkg::CNT_W-1:0] lim);
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= lim;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic send_random(int style);
    logic [lbp_pkg::ACTION_W-1:0] act;
    logic [lbp_pkg::VALUE_W-1:0]  val;
    logic [lbp_pkg::BCOUNT_W-1:0] cnt;
    int                           r;
    int                           a;
    r = $urandom_range(0, 99);
    if (style == STYLE_FILL) begin
      // long-heavy, no clears: runs the buffer into its limit
      if (r < 5)       act = lbp_pkg::ACT_BIT;
      else if (r < 25) act = lbp_pkg::ACT_BITS;
      else if (r < 35) act = lbp_pkg::ACT_BYTE;
      else if (r < 45) act = lbp_pkg::ACT_SHORT;
      else if (r < 90) act = lbp_pkg::ACT_LONG;
      else             act = lbp_pkg::ACT_READ;
    end else if (style == STYLE_DRAIN) begin
      if (r < 70)      act = lbp_pkg::ACT_READ;
      else if (r < 80) act = lbp_pkg::ACT_BITS;
      else if (r < 90) act = lbp_pkg::ACT_LONG;
      else             act = lbp_pkg::ACT_BIT;
    end else begin
      if (r < 3)       act = lbp_pkg::ACT_CLEAR;
      else if (r < 20) act = lbp_pkg::ACT_BIT;
      else if (r < 45) act = lbp_pkg::ACT_BITS;
      else if (r < 55) act = lbp_pkg::ACT_BYTE;
      else if (r < 65) act = lbp_pkg::ACT_SHORT;
      else if (r < 77) act = lbp_pkg::ACT_LONG;
      else if (r < 97) act = lbp_pkg::ACT_READ;
      else             act = ACT_NOP;
    end
    case ($urandom_range(0, 9))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
    // field widths: mostly 1..31, some full, some zero, some clamped above 32
    case ($urandom_range(0, 19))
      0:       cnt = '0;
      1:       cnt = 6'($urandom_range(33, 63));
      2:       cnt = lbp_pkg::MAX_FIELD_BITS;
      default: cnt = 6'($urandom_range(1, 31));
    endcase
    // read addresses: mostly inside the filled part, some at its edge, some anywhere
    case ($urandom_range(0, 3))
      0: a = $urandom_range(0, 1023);
      1: begin
        a = int'(packer_bytes_held) + $urandom_range(0, 2) - 1;
        if (a < 0) a = 0;
      end
      default: a = $urandom_range(0, int'(packer_bytes_held));
    endcase
    send_item(act, val, cnt, a[lbp_pkg::ADDR_W-1:0]);
  endtask

  // out_stall: short random stalls, occasional long ones, and calm stretches
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else begin
      if ($urandom_range(0, 24) == 0) stall_calm = !stall_calm;
      r = $urandom_range(0, 99);
      if (stall_calm) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(5, 40);
      end else if (r < 50) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (r < 97) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(3, 11);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(20, 40);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int lim;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, max_size at its reset value of 1024
    send_item(lbp_pkg::ACT_READ,  '0, '0, '0);                  // read of an empty buffer
    send_item(lbp_pkg::ACT_BIT,   32'h0000_0001, '0, '0);       // opens byte 0
    send_item(lbp_pkg::ACT_BIT,   32'hFFFF_FFFE, '0, '0);       // zero bit still advances
    send_item(lbp_pkg::ACT_BITS,  '1, 6'd0, '0);                // empty field, headroom only
    send_item(lbp_pkg::ACT_BITS,  32'h0000_0015, 6'd5, '0);
    send_item(lbp_pkg::ACT_BYTE,  '1, '0, '0);                  // pointer left mid byte 0
    send_item(lbp_pkg::ACT_BITS,  32'h0000_0007, 6'd3, '0);     // tops up byte 0, opens another
    send_item(lbp_pkg::ACT_SHORT, 32'hFFFF_A55A, '0, '0);
    send_item(lbp_pkg::ACT_LONG,  '0, '0, '0);
    send_item(lbp_pkg::ACT_LONG,  '1, '0, '0);
    send_item(lbp_pkg::ACT_BITS,  '1, lbp_pkg::MAX_FIELD_BITS, '0);  // full 32-bit field
    send_item(lbp_pkg::ACT_BITS,  32'h8000_0001, 6'd33, '0);    // width clamps to 32
    send_item(lbp_pkg::ACT_BITS,  32'h1234_5678, '1, '0);       // widest bit_count
    send_item(lbp_pkg::ACT_BYTE,  '0, '0, '0);
    send_item(lbp_pkg::ACT_SHORT, '0, '0, '0);
    send_item(lbp_pkg::ACT_READ,  '0, '0, 10'd0);
    send_item(lbp_pkg::ACT_READ,  '0, '0, 10'd1);
    send_item(lbp_pkg::ACT_READ,  '0, '0, 10'd2);
    send_item(lbp_pkg::ACT_READ,  '0, '0, 10'd5);
    send_item(lbp_pkg::ACT_READ,  '1, '1, '1);                  // far beyond the byte count
    send_item(ACT_NOP,            '1, '1, '1);
    send_item(lbp_pkg::ACT_CLEAR, '1, '1, '1);
    send_item(lbp_pkg::ACT_READ,  '0, '0, '0);                  // nothing left after clear
    send_item(lbp_pkg::ACT_BIT,   '0, '0, '0);

    // Random phases, one max_size setting each; the last one picks its own
    for (int p = 0; p < NUM_PHASES; p++) begin
      lim = (p == NUM_PHASES - 1) ? $urandom_range(1, 2047) : phase_limit[p];
      set_limit(lim[lbp_pkg::CNT_W-1:0]);
      if (phase_clear[p])
        send_item(lbp_pkg::ACT_CLEAR, $urandom, 6'($urandom), 10'($urandom));
      repeat (phase_items[p]) send_random(phase_style[p]);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (packer_fail == 0 && packer_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
